[hdl/efbd_pkg.sv]
package efbd_pkg;

   // frame limits
   localparam int WAVE_DEPTH     = 1024;
   localparam int SPECTRUM_DEPTH = 256;
   localparam int SC_W           = $clog2(WAVE_DEPTH + 1);
   localparam int BIN_W          = $clog2(SPECTRUM_DEPTH + 1);
   localparam int MEM_AW         = $clog2(SPECTRUM_DEPTH);

   // input queue
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // shared divider widths
   localparam int DIV_N_W = 48;
   localparam int DIV_D_W = 24;

   // configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BINS  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_LVL  = 4'd7;

   // register reset values
   localparam logic signed [15:0] COEF_B0_RST = 16'sd20;
   localparam logic signed [15:0] COEF_B1_RST = 16'sd40;
   localparam logic signed [15:0] COEF_B2_RST = 16'sd20;
   localparam logic signed [15:0] COEF_A1_RST = -16'sd31562;
   localparam logic signed [15:0] COEF_A2_RST = 16'sd15257;
   localparam logic [8:0]         LOW_BINS_RST = 9'd5;
   localparam logic [7:0]         COOLDOWN_RST = 8'd10;
   localparam logic [14:0]        GATE_LVL_RST = 15'd256;

   // running average weights, 0.85 and 0.15 in Q0.16
   localparam logic [24:0] EMA_KEEP = 25'd55706;
   localparam logic [24:0] EMA_GAIN = 25'd9830;

   typedef enum logic {
      KIND_SAMPLE,
      KIND_BIN
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       eof;
   } item_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FILT,
      ST_FY,
      ST_FSQ,
      ST_FACC,
      ST_RDIV,
      ST_RSQRT,
      ST_GATE,
      ST_BIN,
      ST_BOLD,
      ST_WDIV,
      ST_FMUL,
      ST_FLUX,
      ST_BNEXT,
      ST_EOF,
      ST_EDIV,
      ST_EMA1,
      ST_EMA2,
      ST_EMA3,
      ST_EMA4,
      ST_EMA5,
      ST_BEAT,
      ST_EMIT
   } state_type;

endpackage

[hdl/efbd_front.sv]
module efbd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               in_mode,
   input  logic [7:0]         in_value,
   input  logic               in_eof,
   output logic               item_valid,
   output efbd_pkg::item_type item,
   input  logic               item_pop
);

   efbd_pkg::item_type          q_ff [efbd_pkg::QDEPTH];
   logic [efbd_pkg::QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [efbd_pkg::QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [efbd_pkg::QAW:0]      count_ff, count_in;
   efbd_pkg::item_type          cls;
   logic                        do_push, do_pop;

   // classify: the end flag only counts on spectrum bins
   always_comb begin
      cls.kind  = in_mode ? efbd_pkg::KIND_BIN : efbd_pkg::KIND_SAMPLE;
      cls.value = in_value;
      cls.eof   = in_mode & in_eof;
   end

   assign full       = (count_ff == (efbd_pkg::QAW+1)'(efbd_pkg::QDEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = q_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = item_pop & item_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[hdl/efbd_div.sv]
module efbd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  efbd_pkg::div_req_type req,
   output efbd_pkg::div_rsp_type rsp
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [5:0]                    cnt_ff;
   logic [efbd_pkg::DIV_N_W-1:0]  quo_ff;
   logic [efbd_pkg::DIV_D_W:0]    rem_ff;
   logic [efbd_pkg::DIV_D_W-1:0]  dsr_ff;
   logic [efbd_pkg::DIV_D_W:0]    rem_sh;
   logic                          q_bit;

   // one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff[efbd_pkg::DIV_D_W-1:0], quo_ff[efbd_pkg::DIV_N_W-1]};
      q_bit  = (rem_sh >= {1'b0, dsr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 6'(efbd_pkg::DIV_N_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         cnt_ff <= '0;
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         quo_ff <= {quo_ff[efbd_pkg::DIV_N_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_sh - {1'b0, dsr_ff} : rem_sh;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

[hdl/efbd_back.sv]
module efbd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [efbd_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [15:0]                     csr_wdata,
   input  logic                            item_valid,
   input  efbd_pkg::item_type              item,
   output logic                            item_pop,
   output efbd_pkg::div_req_type           div_req,
   input  efbd_pkg::div_rsp_type           div_rsp,
   output logic                            empty,
   input  logic                            pop,
   output logic                            beat_detected,
   output logic                            gated,
   output logic [15:0]                     rms_energy,
   output logic [15:0]                     flux_value
);

   efbd_pkg::state_type state_ff, state_in;
   efbd_pkg::item_type  item_ff;

   // configuration
   logic signed [15:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [8:0]         low_bins_ff;
   logic [7:0]         cool_frames_ff;
   logic [14:0]        gate_ff;

   // filter and frame state
   logic signed [7:0]  in_h1_ff, in_h2_ff;
   logic signed [23:0] out_h1_ff, out_h2_ff;
   logic [47:0]        energy_ff;
   logic [efbd_pkg::SC_W-1:0]  scount_ff;
   logic [15:0]        rms_ff;
   logic               gated_ff;
   logic [23:0]        avg_e_ff, avg_f_ff;
   logic [efbd_pkg::BIN_W-1:0] bin_ff;
   logic [31:0]        flux_sum_ff;
   logic [23:0]        wsum_ff;
   logic [7:0]         cool_ff;

   // previous spectrum
   logic [7:0]                       spec_mem [efbd_pkg::SPECTRUM_DEPTH];
   logic [efbd_pkg::SPECTRUM_DEPTH-1:0] spec_vld_ff;
   logic [7:0]                       rd_data_ff;
   logic                             rd_vld_ff;
   logic [efbd_pkg::MEM_AW-1:0]      mem_addr;

   // working registers
   logic signed [47:0] acc_ff;
   logic [2:0]         fcnt_ff;
   logic signed [23:0] y_ff;
   logic signed [49:0] prod_ff;
   logic signed [24:0] mul_a, mul_b;
   logic [47:0]        sq_n_ff, sq_r_ff, sq_bit_ff;
   logic [7:0]         old_ff;
   logic [16:0]        w_ff;
   logic [15:0]        flux_ff;
   logic [40:0]        t1_ff;
   logic               beat_ff;

   // result register
   logic               rsp_vld_ff;
   logic               rsp_beat_ff, rsp_gated_ff;
   logic [15:0]        rsp_rms_ff, rsp_flux_ff;

   // helpers
   logic signed [7:0]  x_cur;
   logic signed [47:0] term;
   logic signed [47:0] y_shift;
   logic signed [23:0] y_sat;
   logic [48:0]        esum;
   logic [47:0]        sq_try;
   logic [15:0]        rms_sat;
   logic [7:0]         old_val;
   logic [32:0]        fsum;
   logic [40:0]        ema_sum;
   logic [27:0]        rms_x, ae_x, flux_x, af_x;
   logic [20:0]        rms20;
   logic               beat_ok;
   logic               bin_in_range, bin_is_low;
   logic               out_free;
   logic               smp_drop;

   assign mem_addr     = bin_ff[efbd_pkg::MEM_AW-1:0];
   assign x_cur        = signed'({~item_ff.value[7], item_ff.value[6:0]});
   assign bin_in_range = (bin_ff < efbd_pkg::BIN_W'(efbd_pkg::SPECTRUM_DEPTH));
   assign bin_is_low   = (bin_ff < low_bins_ff);
   assign out_free     = ~rsp_vld_ff | pop;
   assign smp_drop     = (bin_ff != '0) ||
                         (scount_ff >= efbd_pkg::SC_W'(efbd_pkg::WAVE_DEPTH));

   // arithmetic helpers
   always_comb begin
      term    = signed'(prod_ff[47:0]);
      y_shift = (acc_ff + 48'sd8192) >>> 14;
      if (y_shift > 48'sd8388607) begin
         y_sat = 24'sd8388607;
      end else if (y_shift < -48'sd8388608) begin
         y_sat = -24'sd8388608;
      end else begin
         y_sat = y_shift[23:0];
      end
      esum    = {1'b0, energy_ff} + {1'b0, prod_ff[47:0]};
      sq_try  = sq_r_ff + sq_bit_ff;
      rms_sat = (|sq_r_ff[47:16]) ? 16'hFFFF : sq_r_ff[15:0];
      old_val = rd_vld_ff ? rd_data_ff : 8'd0;
      fsum    = {1'b0, flux_sum_ff} + 33'(prod_ff[31:0]);
      ema_sum = t1_ff + prod_ff[40:0] + 41'd32768;
      rms_x   = (28'(rms_ff) << 11) + (28'(rms_ff) << 9);
      ae_x    = (28'(avg_e_ff) << 3) + (28'(avg_e_ff) << 2) + 28'(avg_e_ff);
      flux_x  = (28'(flux_ff) << 11) + (28'(flux_ff) << 9);
      af_x    = (28'(avg_f_ff) << 3) + (28'(avg_f_ff) << 2) + (28'(avg_f_ff) << 1);
      rms20   = (21'(rms_ff) << 4) + (21'(rms_ff) << 2);
      beat_ok = (cool_ff >= cool_frames_ff) && (rms_x > ae_x) &&
                (flux_x > af_x) && (rms20 > 21'd768);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efbd_pkg::ST_IDLE: begin
            if (item_valid) begin
               if (item.kind == efbd_pkg::KIND_SAMPLE) begin
                  state_in = smp_drop ? efbd_pkg::ST_IDLE : efbd_pkg::ST_FILT;
               end else if (bin_ff != '0) begin
                  state_in = efbd_pkg::ST_BIN;
               end else if (scount_ff == '0) begin
                  state_in = efbd_pkg::ST_GATE;
               end else begin
                  state_in = efbd_pkg::ST_RDIV;
               end
            end
         end
         efbd_pkg::ST_FILT: begin
            if (fcnt_ff == 3'd5) state_in = efbd_pkg::ST_FY;
         end
         efbd_pkg::ST_FY:   state_in = efbd_pkg::ST_FSQ;
         efbd_pkg::ST_FSQ:  state_in = efbd_pkg::ST_FACC;
         efbd_pkg::ST_FACC: state_in = efbd_pkg::ST_IDLE;
         efbd_pkg::ST_RDIV: begin
            if (div_rsp.done) state_in = efbd_pkg::ST_RSQRT;
         end
         efbd_pkg::ST_RSQRT: begin
            if (sq_bit_ff[0]) state_in = efbd_pkg::ST_GATE;
         end
         efbd_pkg::ST_GATE: state_in = efbd_pkg::ST_BIN;
         efbd_pkg::ST_BIN: begin
            if (!bin_in_range) begin
               state_in = item_ff.eof ? efbd_pkg::ST_EOF : efbd_pkg::ST_IDLE;
            end else if (gated_ff) begin
               state_in = efbd_pkg::ST_BNEXT;
            end else begin
               state_in = efbd_pkg::ST_BOLD;
            end
         end
         efbd_pkg::ST_BOLD: begin
            state_in = bin_is_low ? efbd_pkg::ST_WDIV : efbd_pkg::ST_BNEXT;
         end
         efbd_pkg::ST_WDIV: begin
            if (div_rsp.done) state_in = efbd_pkg::ST_FMUL;
         end
         efbd_pkg::ST_FMUL: state_in = efbd_pkg::ST_FLUX;
         efbd_pkg::ST_FLUX: state_in = efbd_pkg::ST_BNEXT;
         efbd_pkg::ST_BNEXT: begin
            state_in = item_ff.eof ? efbd_pkg::ST_EOF : efbd_pkg::ST_IDLE;
         end
         efbd_pkg::ST_EOF: begin
            if (gated_ff) begin
               state_in = efbd_pkg::ST_EMIT;
            end else if (wsum_ff == '0) begin
               state_in = efbd_pkg::ST_EMA1;
            end else begin
               state_in = efbd_pkg::ST_EDIV;
            end
         end
         efbd_pkg::ST_EDIV: begin
            if (div_rsp.done) state_in = efbd_pkg::ST_EMA1;
         end
         efbd_pkg::ST_EMA1: state_in = efbd_pkg::ST_EMA2;
         efbd_pkg::ST_EMA2: state_in = efbd_pkg::ST_EMA3;
         efbd_pkg::ST_EMA3: state_in = efbd_pkg::ST_EMA4;
         efbd_pkg::ST_EMA4: state_in = efbd_pkg::ST_EMA5;
         efbd_pkg::ST_EMA5: state_in = efbd_pkg::ST_BEAT;
         efbd_pkg::ST_BEAT: state_in = efbd_pkg::ST_EMIT;
         efbd_pkg::ST_EMIT: begin
            if (out_free) state_in = efbd_pkg::ST_IDLE;
         end
         default: state_in = efbd_pkg::ST_IDLE;
      endcase
   end

   // control outputs: queue pop, multiplier operands, divider requests
   always_comb begin
      item_pop         = 1'b0;
      mul_a            = '0;
      mul_b            = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      unique case (state_ff)
         efbd_pkg::ST_IDLE: begin
            item_pop = item_valid;
            if (item_valid && item.kind == efbd_pkg::KIND_BIN &&
                bin_ff == '0 && scount_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = energy_ff;
               div_req.divisor  = efbd_pkg::DIV_D_W'(scount_ff);
            end
         end
         efbd_pkg::ST_FILT: begin
            unique case (fcnt_ff)
               3'd0: begin mul_a = 25'(b0_ff); mul_b = 25'(x_cur);     end
               3'd1: begin mul_a = 25'(b1_ff); mul_b = 25'(in_h1_ff);  end
               3'd2: begin mul_a = 25'(b2_ff); mul_b = 25'(in_h2_ff);  end
               3'd3: begin mul_a = 25'(a1_ff); mul_b = 25'(out_h1_ff); end
               3'd4: begin mul_a = 25'(a2_ff); mul_b = 25'(out_h2_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         efbd_pkg::ST_FSQ: begin
            mul_a = 25'(y_ff);
            mul_b = 25'(y_ff);
         end
         efbd_pkg::ST_BOLD: begin
            if (bin_is_low) begin
               div_req.start    = 1'b1;
               div_req.dividend = 48'd65536;
               div_req.divisor  = efbd_pkg::DIV_D_W'(bin_ff) + 1'b1;
            end
         end
         efbd_pkg::ST_FMUL: begin
            mul_a = signed'(25'(item_ff.value - old_ff));
            mul_b = signed'(25'(w_ff));
         end
         efbd_pkg::ST_EOF: begin
            if (!gated_ff && wsum_ff != '0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, flux_sum_ff, 8'd0};
               div_req.divisor  = wsum_ff;
            end
         end
         efbd_pkg::ST_EMA1: begin
            mul_a = signed'({1'b0, avg_e_ff});
            mul_b = signed'(efbd_pkg::EMA_KEEP);
         end
         efbd_pkg::ST_EMA2: begin
            mul_a = signed'({1'b0, rms_ff, 8'd0});
            mul_b = signed'(efbd_pkg::EMA_GAIN);
         end
         efbd_pkg::ST_EMA3: begin
            mul_a = signed'({1'b0, avg_f_ff});
            mul_b = signed'(efbd_pkg::EMA_KEEP);
         end
         efbd_pkg::ST_EMA4: begin
            mul_a = signed'({1'b0, flux_ff, 8'd0});
            mul_b = signed'(efbd_pkg::EMA_GAIN);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // state register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= efbd_pkg::ST_IDLE;
         b0_ff          <= efbd_pkg::COEF_B0_RST;
         b1_ff          <= efbd_pkg::COEF_B1_RST;
         b2_ff          <= efbd_pkg::COEF_B2_RST;
         a1_ff          <= efbd_pkg::COEF_A1_RST;
         a2_ff          <= efbd_pkg::COEF_A2_RST;
         low_bins_ff    <= efbd_pkg::LOW_BINS_RST;
         cool_frames_ff <= efbd_pkg::COOLDOWN_RST;
         gate_ff        <= efbd_pkg::GATE_LVL_RST;
         in_h1_ff       <= '0;
         in_h2_ff       <= '0;
         out_h1_ff      <= '0;
         out_h2_ff      <= '0;
         energy_ff      <= '0;
         scount_ff      <= '0;
         rms_ff         <= '0;
         gated_ff       <= 1'b0;
         avg_e_ff       <= '0;
         avg_f_ff       <= '0;
         bin_ff         <= '0;
         flux_sum_ff    <= '0;
         wsum_ff        <= '0;
         cool_ff        <= efbd_pkg::COOLDOWN_RST;
         spec_vld_ff    <= '0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;

         // register writes
         if (csr_we) begin
            unique case (csr_idx)
               efbd_pkg::CSR_COEF_B0:  b0_ff          <= signed'(csr_wdata);
               efbd_pkg::CSR_COEF_B1:  b1_ff          <= signed'(csr_wdata);
               efbd_pkg::CSR_COEF_B2:  b2_ff          <= signed'(csr_wdata);
               efbd_pkg::CSR_COEF_A1:  a1_ff          <= signed'(csr_wdata);
               efbd_pkg::CSR_COEF_A2:  a2_ff          <= signed'(csr_wdata);
               efbd_pkg::CSR_LOW_BINS: low_bins_ff    <= csr_wdata[8:0];
               efbd_pkg::CSR_COOLDOWN: cool_frames_ff <= csr_wdata[7:0];
               efbd_pkg::CSR_GATE_LVL: gate_ff        <= csr_wdata[14:0];
               default: ;
            endcase
         end

         unique case (state_ff)
            efbd_pkg::ST_FY: begin
               in_h2_ff  <= in_h1_ff;
               in_h1_ff  <= x_cur;
               out_h2_ff <= out_h1_ff;
               out_h1_ff <= y_sat;
            end
            efbd_pkg::ST_FACC: begin
               energy_ff <= esum[48] ? 48'hFFFF_FFFF_FFFF : esum[47:0];
               scount_ff <= scount_ff + 1'b1;
            end
            efbd_pkg::ST_GATE: begin
               rms_ff   <= rms_sat;
               gated_ff <= (rms_sat < {1'b0, gate_ff});
            end
            efbd_pkg::ST_BOLD: begin
               spec_vld_ff[mem_addr] <= 1'b1;
            end
            efbd_pkg::ST_WDIV: begin
               if (div_rsp.done) begin
                  wsum_ff <= wsum_ff + 24'(div_rsp.quotient[16:0]);
               end
            end
            efbd_pkg::ST_FLUX: begin
               if (item_ff.value > old_ff) begin
                  flux_sum_ff <= fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
               end
            end
            efbd_pkg::ST_BNEXT: begin
               bin_ff <= bin_ff + 1'b1;
            end
            efbd_pkg::ST_EMA3: avg_e_ff <= ema_sum[39:16];
            efbd_pkg::ST_EMA5: avg_f_ff <= ema_sum[39:16];
            efbd_pkg::ST_BEAT: begin
               if (beat_ok) begin
                  cool_ff <= '0;
               end else if (cool_ff != 8'hFF) begin
                  cool_ff <= cool_ff + 1'b1;
               end
            end
            efbd_pkg::ST_EMIT: begin
               if (out_free) begin
                  energy_ff   <= '0;
                  scount_ff   <= '0;
                  bin_ff      <= '0;
                  flux_sum_ff <= '0;
                  wsum_ff     <= '0;
               end
            end
            default: ;
         endcase

         // result register
         if (state_ff == efbd_pkg::ST_EMIT && out_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (pop) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         efbd_pkg::ST_IDLE: begin
            if (item_valid) item_ff <= item;
            acc_ff  <= '0;
            fcnt_ff <= '0;
            sq_r_ff <= '0;
         end
         efbd_pkg::ST_FILT: begin
            fcnt_ff <= fcnt_ff + 1'b1;
            if (fcnt_ff != 3'd0) begin
               if (fcnt_ff <= 3'd3) begin
                  acc_ff <= acc_ff + (term <<< 8);
               end else begin
                  acc_ff <= acc_ff - term;
               end
            end
         end
         efbd_pkg::ST_FY: y_ff <= y_sat;
         efbd_pkg::ST_RDIV: begin
            sq_n_ff   <= div_rsp.quotient;
            sq_r_ff   <= '0;
            sq_bit_ff <= 48'h4000_0000_0000;
         end
         efbd_pkg::ST_RSQRT: begin
            if (sq_n_ff >= sq_try) begin
               sq_n_ff <= sq_n_ff - sq_try;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         efbd_pkg::ST_BOLD: old_ff <= old_val;
         efbd_pkg::ST_WDIV: w_ff <= div_rsp.quotient[16:0];
         efbd_pkg::ST_EOF: flux_ff <= '0;
         efbd_pkg::ST_EDIV: begin
            flux_ff <= (|div_rsp.quotient[47:16]) ? 16'hFFFF : div_rsp.quotient[15:0];
         end
         efbd_pkg::ST_EMA2: t1_ff <= prod_ff[40:0];
         efbd_pkg::ST_EMA4: t1_ff <= prod_ff[40:0];
         // hold the decision, cooldown changes on this edge
         efbd_pkg::ST_BEAT: beat_ff <= beat_ok;
         efbd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_beat_ff  <= (~gated_ff) & beat_ff;
               rsp_gated_ff <= gated_ff;
               rsp_rms_ff   <= rms_ff;
               rsp_flux_ff  <= gated_ff ? 16'd0 : flux_ff;
            end
         end
         default: ;
      endcase
   end

   // previous spectrum memory, registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= spec_mem[mem_addr];
      rd_vld_ff  <= spec_vld_ff[mem_addr];
      if (state_ff == efbd_pkg::ST_BOLD) begin
         spec_mem[mem_addr] <= item_ff.value;
      end
   end

   assign empty         = ~rsp_vld_ff;
   assign beat_detected = rsp_beat_ff;
   assign gated         = rsp_gated_ff;
   assign rms_energy    = rsp_rms_ff;
   assign flux_value    = rsp_flux_ff;

endmodule

[hdl/energy_flux_beat_detector_top.sv]
// Channel   Direction  Handshake              Payload
// request   in         push / full            req_mode, req_value, req_end_of_frame
// response  out        pop / empty            rsp_beat_detected, rsp_gated,
//                                             rsp_rms_energy, rsp_flux_value
// config    in         csr_we                 csr_idx, csr_wdata
//
// A waveform sample in the back end runs five filter products through the one shared
// 25x25 multiplier, then rounding, squaring and accumulation.
// The first bin of a frame with samples runs a 48-step divider and a 24-step root first.
// Ungated frames add a weight division per low bin, then averages and any flux division.
// Reset is synchronous; spectrum history valid bits clear at once, no clearing pass.
// A four-entry input queue and a one-entry result register let either side stall alone.
module energy_flux_beat_detector_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_mode,
   input  logic [7:0]                     req_value,
   input  logic                           req_end_of_frame,
   output logic                           empty,
   input  logic                           pop,
   output logic                           rsp_beat_detected,
   output logic                           rsp_gated,
   output logic [15:0]                    rsp_rms_energy,
   output logic [15:0]                    rsp_flux_value,
   input  logic                           csr_we,
   input  logic [efbd_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [15:0]                    csr_wdata
);

   logic                  item_valid;
   logic                  item_pop;
   efbd_pkg::item_type    item;
   efbd_pkg::div_req_type div_req;
   efbd_pkg::div_rsp_type div_rsp;

   // front end: accept and classify
   efbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .in_mode    (req_mode),
      .in_value   (req_value),
      .in_eof     (req_end_of_frame),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   // shared divider
   efbd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // back end: filter, rms, flux, beat decision
   efbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_idx       (csr_idx),
      .csr_wdata     (csr_wdata),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .empty         (empty),
      .pop           (pop),
      .beat_detected (rsp_beat_detected),
      .gated         (rsp_gated),
      .rms_energy    (rsp_rms_energy),
      .flux_value    (rsp_flux_value)
   );

endmodule

[hdl/efbd_checker.sv]
module efbd_port_props (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_beat_detected,
   input logic        rsp_gated,
   input logic [15:0] rsp_rms_energy,
   input logic [15:0] rsp_flux_value
);

   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result present after reset");

   // a gated frame reports no flux
   a_gated_flux: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_gated) |-> (rsp_flux_value == 16'd0))
      else $error("gated frame with nonzero flux");

   // a beat never comes from a gated frame
   a_beat_gate: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_beat_detected) |-> !rsp_gated)
      else $error("beat on gated frame");

   // a beat needs rms above 0.15
   a_beat_rms: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_beat_detected) |-> (rsp_rms_energy > 16'd38))
      else $error("beat with low rms");

   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rms_energy) && $stable(rsp_flux_value)))
      else $error("waiting result changed");

endmodule

bind energy_flux_beat_detector_top efbd_port_props u_efbd_port_props (
   .clock             (clock),
   .reset             (reset),
   .empty             (empty),
   .pop               (pop),
   .rsp_beat_detected (rsp_beat_detected),
   .rsp_gated         (rsp_gated),
   .rsp_rms_energy    (rsp_rms_energy),
   .rsp_flux_value    (rsp_flux_value)
);

[dv/efbd_checker.sv]
module efbd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  logic                           req_mode,
   input  logic [7:0]                     req_value,
   input  logic                           req_end_of_frame,
   input  logic                           empty,
   input  logic                           pop,
   input  logic                           rsp_beat_detected,
   input  logic                           rsp_gated,
   input  logic [15:0]                    rsp_rms_energy,
   input  logic [15:0]                    rsp_flux_value,
   input  logic                           csr_we,
   input  logic [efbd_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [15:0]                    csr_wdata,
   output int                             fail_count,
   output int                             frames_pending,
   output int                             frames_checked,
   output int                             beats_seen,
   output int                             gated_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        beat;
      logic        gated;
      logic [15:0] rms;
      logic [15:0] flux;
   } frame_result_type;

   frame_result_type frame_q[$];

   // register copy
   logic signed [15:0] b0, b1, b2, a1, a2;
   logic [8:0]         low_bins;
   logic [7:0]         cool_frames;
   logic [14:0]        gate_lvl;

   // block state copy
   longint            x1, x2, y1, y2;
   longint unsigned   e_sum;
   int unsigned       n_samples;
   int unsigned       cur_rms;
   bit                cur_gated;
   longint unsigned   e_avg, f_avg;
   logic [7:0]        last_mag [efbd_pkg::SPECTRUM_DEPTH];
   int unsigned       bin_pos;
   longint unsigned   f_sum, w_sum;
   int unsigned       cool_cnt;

   assign frames_pending = frame_q.size();

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned run_avg(longint unsigned avg, longint unsigned x88);
      longint unsigned t;
      t = avg * 55706 + (x88 << 8) * 9830 + 32768;
      return (t >> 16) & 64'hFF_FFFF;
   endfunction

   task automatic mismatch(input string what, input longint got, input longint want);
      $display("mismatch frame %0d %s: got %0d want %0d", frames_checked, what, got, want);
      fail_count++;
   endtask

   // biquad, square and accumulate one waveform sample
   task automatic filter_step(input logic [7:0] v);
      longint x, acc, y;
      x   = longint'(v) - 128;
      acc = (longint'(b0) * x + longint'(b1) * x1 + longint'(b2) * x2) * 256
            - (longint'(a1) * y1 + longint'(a2) * y2);
      y   = (acc + 8192) >>> 14;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      x2 = x1; x1 = x;
      y2 = y1; y1 = y;
      e_sum = e_sum + longint'(y * y);
      if (e_sum > 64'hFFFF_FFFF_FFFF) e_sum = 64'hFFFF_FFFF_FFFF;
   endtask

   // one accepted input transfer
   task automatic predict_item(input logic mode, input logic [7:0] v, input logic eof);
      frame_result_type res;
      longint unsigned r, w, fl;
      if (efbd_pkg::kind_type'(mode) == efbd_pkg::KIND_SAMPLE) begin
         if (bin_pos == 0 && n_samples < efbd_pkg::WAVE_DEPTH) begin
            filter_step(v);
            n_samples++;
         end
         return;
      end
      if (bin_pos == 0) begin
         r = 0;
         if (n_samples != 0) r = int_sqrt(e_sum / n_samples);
         if (r > 65535) r = 65535;
         cur_rms   = 32'(r);
         cur_gated = cur_rms < gate_lvl;
      end
      if (bin_pos < efbd_pkg::SPECTRUM_DEPTH) begin
         if (!cur_gated) begin
            if (bin_pos < low_bins) begin
               w = 65536 / (bin_pos + 1);
               w_sum = (w_sum + w) & 64'hFF_FFFF;
               if (v > last_mag[bin_pos]) begin
                  f_sum = f_sum + (v - last_mag[bin_pos]) * w;
                  if (f_sum > 64'hFFFF_FFFF) f_sum = 64'hFFFF_FFFF;
               end
            end
            last_mag[bin_pos] = v;
         end
         bin_pos++;
      end
      if (!eof) return;
      fl = 0;
      res.beat = 1'b0;
      if (!cur_gated) begin
         if (w_sum != 0) fl = (f_sum << 8) / w_sum;
         if (fl > 65535) fl = 65535;
         e_avg = run_avg(e_avg, cur_rms);
         f_avg = run_avg(f_avg, fl);
         if (cool_cnt >= cool_frames && longint'(cur_rms) * 2560 > e_avg * 13
             && fl * 2560 > f_avg * 14 && cur_rms * 20 > 768) begin
            res.beat = 1'b1;
            cool_cnt = 0;
         end else if (cool_cnt < 255) begin
            cool_cnt++;
         end
      end
      res.gated = cur_gated;
      res.rms   = cur_rms[15:0];
      res.flux  = fl[15:0];
      frame_q.push_back(res);
      e_sum = 0; n_samples = 0; bin_pos = 0; f_sum = 0; w_sum = 0;
   endtask

   // watch all three ports
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         b0 = efbd_pkg::COEF_B0_RST; b1 = efbd_pkg::COEF_B1_RST;
         b2 = efbd_pkg::COEF_B2_RST;
         a1 = efbd_pkg::COEF_A1_RST; a2 = efbd_pkg::COEF_A2_RST;
         low_bins = efbd_pkg::LOW_BINS_RST; cool_frames = efbd_pkg::COOLDOWN_RST;
         gate_lvl = efbd_pkg::GATE_LVL_RST;
         x1 = 0; x2 = 0; y1 = 0; y2 = 0;
         e_sum = 0; n_samples = 0; cur_rms = 0; cur_gated = 0;
         e_avg = 0; f_avg = 0;
         foreach (last_mag[i]) last_mag[i] = 8'd0;
         bin_pos = 0; f_sum = 0; w_sum = 0;
         cool_cnt = 32'(efbd_pkg::COOLDOWN_RST);
         frame_q.delete();
      end else begin
         if (pop && !empty) begin
            if (frame_q.size() == 0) begin
               mismatch("unexpected result", rsp_rms_energy, -1);
            end else begin
               want = frame_q.pop_front();
               if (rsp_beat_detected !== want.beat)
                  mismatch("beat_detected", rsp_beat_detected, want.beat);
               if (rsp_gated !== want.gated) mismatch("gated", rsp_gated, want.gated);
               if (rsp_rms_energy !== want.rms)
                  mismatch("rms_energy", rsp_rms_energy, want.rms);
               if (rsp_flux_value !== want.flux)
                  mismatch("flux_value", rsp_flux_value, want.flux);
               if (want.beat) beats_seen++;
               if (want.gated) gated_seen++;
            end
            frames_checked++;
         end
         if (push && !full) predict_item(req_mode, req_value, req_end_of_frame);
         if (csr_we) begin
            case (csr_idx)
               efbd_pkg::CSR_COEF_B0:  b0 = csr_wdata;
               efbd_pkg::CSR_COEF_B1:  b1 = csr_wdata;
               efbd_pkg::CSR_COEF_B2:  b2 = csr_wdata;
               efbd_pkg::CSR_COEF_A1:  a1 = csr_wdata;
               efbd_pkg::CSR_COEF_A2:  a2 = csr_wdata;
               efbd_pkg::CSR_LOW_BINS: low_bins = csr_wdata[8:0];
               efbd_pkg::CSR_COOLDOWN: cool_frames = csr_wdata[7:0];
               efbd_pkg::CSR_GATE_LVL: gate_lvl = csr_wdata[14:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      fail_count = 0;
      frames_checked = 0;
      beats_seen = 0;
      gated_seen = 0;
   end

endmodule

[dv/tb_energy_flux_beat_detector_top.sv]
module tb_energy_flux_beat_detector_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic push, full, req_mode, req_end_of_frame;
   logic [7:0] req_value;
   logic empty, pop;
   logic rsp_beat_detected, rsp_gated;
   logic [15:0] rsp_rms_energy, rsp_flux_value;
   logic csr_we;
   logic [efbd_pkg::CSR_IDX_W-1:0] csr_idx;
   logic [15:0] csr_wdata;

   int fail_count, frames_pending, frames_checked, beats_seen, gated_seen;
   int items_sent;
   bit no_gaps, rx_no_gaps, stim_done;

   energy_flux_beat_detector_top u_top (.*);

   efbd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender gap per item, 0..18, or none during burst stretches
   function automatic int draw_gap(bit burst);
      if (burst) return 0;
      if ($urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic send(input logic mode, input logic [7:0] v, input logic eof);
      int gap;
      gap = draw_gap(no_gaps);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode <= mode;
      req_value <= v;
      req_end_of_frame <= eof;
      push <= 1'b1;
      do @(posedge clock); while (full);
      items_sent++;
   endtask

   // write enable stays high across a run of writes; the caller drops it
   task automatic csr_write(input logic [efbd_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] d);
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   // drain all results, then let trailing bins finish before touching registers
   task automatic drain;
      push <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coef();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 8000));
         3: return 16'(-$urandom_range(0, 8000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic set_phase(input int ph);
      logic [15:0] lb, cd, gl;
      case (ph)
         1: begin lb = 16'd256; cd = 16'd0; gl = 16'd0; end
         2: begin lb = 16'd0; cd = 16'd255; gl = 16'h7FFF; end
         3: begin lb = 16'd1; cd = 16'd1; gl = 16'd1; end
         default: begin
            lb = 16'($urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0) lb = 16'($urandom_range(0, 256));
            cd = 16'($urandom_range(0, 4));
            gl = 16'($urandom_range(0, 3000));
         end
      endcase
      if (ph == 1) begin
         csr_write(efbd_pkg::CSR_COEF_B0, 16'h7FFF);
         csr_write(efbd_pkg::CSR_COEF_B1, 16'h8000);
         csr_write(efbd_pkg::CSR_COEF_B2, 16'h7FFF);
         csr_write(efbd_pkg::CSR_COEF_A1, 16'h8000);
         csr_write(efbd_pkg::CSR_COEF_A2, 16'h7FFF);
      end else if (ph == 4) begin
         // passthrough-ish filter, lively RMS
         csr_write(efbd_pkg::CSR_COEF_B0, 16'd16384);
         csr_write(efbd_pkg::CSR_COEF_B1, 16'd0);
         csr_write(efbd_pkg::CSR_COEF_B2, 16'd0);
         csr_write(efbd_pkg::CSR_COEF_A1, 16'd0);
         csr_write(efbd_pkg::CSR_COEF_A2, 16'd0);
      end else begin
         csr_write(efbd_pkg::CSR_COEF_B0, pick_coef());
         csr_write(efbd_pkg::CSR_COEF_B1, pick_coef());
         csr_write(efbd_pkg::CSR_COEF_B2, pick_coef());
         csr_write(efbd_pkg::CSR_COEF_A1, pick_coef());
         csr_write(efbd_pkg::CSR_COEF_A2, pick_coef());
      end
      csr_write(efbd_pkg::CSR_LOW_BINS, lb);
      csr_write(efbd_pkg::CSR_COOLDOWN, cd);
      csr_write(efbd_pkg::CSR_GATE_LVL, gl);
      csr_we <= 1'b0;
   endtask

   // one frame with random content, sometimes broken
   task automatic random_frame(input int n_wave, input int n_bins);
      int amp, j;
      amp = $urandom_range(0, 127);
      for (j = 0; j < n_wave; j++)
         send(efbd_pkg::KIND_SAMPLE, 8'(128 + $urandom_range(0, 2 * amp) - amp),
              $urandom_range(0, 9) == 0);
      for (j = 0; j < n_bins; j++) begin
         if ($urandom_range(0, 19) == 0)
            send(efbd_pkg::KIND_SAMPLE, 8'($urandom), 1'($urandom));
         send(efbd_pkg::KIND_BIN, 8'($urandom), j == n_bins - 1);
      end
   endtask

   // result side: random stalls per result, pop held across back-to-back transfers
   initial begin
      int n;
      pop = 1'b0;
      @(negedge reset);
      n = $urandom_range(0, 18);
      forever begin
         if (n > 0) begin
            pop <= 1'b0;
            repeat (n) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         n = rx_no_gaps ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 30) == 0) rx_no_gaps = ~rx_no_gaps;
      end
   end

   initial begin
      int ph, fr, nw, nb;
      reset = 1'b1;
      push = 1'b0;
      req_mode = 1'b0;
      req_value = 8'd0;
      req_end_of_frame = 1'b0;
      csr_we = 1'b0;
      csr_idx = '0;
      csr_wdata = '0;
      items_sent = 0;
      no_gaps = 0;
      rx_no_gaps = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty frames, stray flags, waveform after bins
      send(efbd_pkg::KIND_BIN, 8'd255, 1'b1);
      send(efbd_pkg::KIND_SAMPLE, 8'd0, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd255, 1'b1);
      send(efbd_pkg::KIND_SAMPLE, 8'd0, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd255, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd128, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd255, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd255, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd1, 1'b1);
      send(efbd_pkg::KIND_SAMPLE, 8'd128, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd128, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd200, 1'b1);
      send(efbd_pkg::KIND_SAMPLE, 8'd10, 1'b0);
      send(efbd_pkg::KIND_SAMPLE, 8'd250, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b0);
      send(efbd_pkg::KIND_BIN, 8'd0, 1'b1);
      drain();

      // random phases, registers changed only while idle
      fr = 0;
      for (ph = 1; ph <= 9; ph++) begin
         set_phase(ph);
         repeat (ph == 1 ? 15 : 25) begin
            fr++;
            if ($urandom_range(0, 5) == 0) no_gaps = ~no_gaps;
            nw = $urandom_range(0, 10);
            nb = $urandom_range(1, 8);
            if (fr == 40) nw = efbd_pkg::WAVE_DEPTH + 3;
            if (fr == 80) nb = efbd_pkg::SPECTRUM_DEPTH + 4;
            if (fr == 120) begin nw = 6; nb = efbd_pkg::SPECTRUM_DEPTH; end
            random_frame(nw, nb);
            if (items_sent >= 1850) break;
         end
         drain();
         if (items_sent >= 1850) break;
      end

      $display("sent %0d items, checked %0d frames: %0d beats, %0d gated",
               items_sent, frames_checked, beats_seen, gated_seen);
      if (fail_count == 0) begin
         $display("tb_energy_flux_beat_detector_top passed");
      end else begin
         $display("tb_energy_flux_beat_detector_top failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb_energy_flux_beat_detector_top failed");
      $finish;
   end

endmodule

[energy_flux_beat_detector_top.f]
hdl/efbd_pkg.sv
hdl/efbd_front.sv
hdl/efbd_div.sv
hdl/efbd_back.sv
hdl/energy_flux_beat_detector_top.sv
hdl/efbd_checker.sv
dv/efbd_checker.sv
dv/tb_energy_flux_beat_detector_top.sv
